[rtl/core/ecnq_pkg.sv]
// Shared types and constants of the ECN marking pausable queue.
package ecnq_pkg;

  localparam int CMD_W   = 2;
  localparam int BYTES_W = 14;
  localparam int QUANT_W = 16;
  localparam int OCC_W   = 20;
  localparam int STATE_W = 2;
  localparam int DROP_W  = 32;
  localparam int CFG_W   = 32;
  localparam int PADDR_W = 3;

  // largest packet that may be queued; larger arrivals are dropped
  localparam logic [16:0] MAX_PACKET_BYTES = 17'd9216;

  // event commands
  localparam logic [CMD_W-1:0] CMD_DATA    = 2'd0;
  localparam logic [CMD_W-1:0] CMD_PAUSE   = 2'd1;
  localparam logic [CMD_W-1:0] CMD_SERVICE = 2'd2;

  // sender states reported in send_state
  localparam logic [STATE_W-1:0] SEND_READY      = 2'd0;
  localparam logic [STATE_W-1:0] SEND_PAUSE_RCVD = 2'd1;
  localparam logic [STATE_W-1:0] SEND_PAUSED     = 2'd2;

  // configuration register indexes (byte address bit 2)
  localparam logic REG_MAX_BYTES     = 1'b0;
  localparam logic REG_ECN_THRESHOLD = 1'b1;

  localparam logic [OCC_W-1:0] MAX_BYTES_RESET     = 20'd1048575;
  localparam logic [OCC_W-1:0] ECN_THRESHOLD_RESET = 20'd65536;

  // controller to datapath commands
  typedef struct packed {
    logic load;    // capture the accepted event word
    logic commit;  // execute the event and load the result register
  } ecnq_cmd_t;

  // one result word
  typedef struct packed {
    logic               dropped;
    logic               marked_ce;
    logic [BYTES_W-1:0] departed_bytes;
    logic               start_service;
    logic [STATE_W-1:0] send_state;
    logic [OCC_W-1:0]   occupancy_bytes;
    logic [DROP_W-1:0]  drop_total;
    logic               underflow_error;
  } ecnq_result_t;

endpackage

[rtl/core/ecnq_evt_if.sv]
// Event channel: valid/ready handshake carrying one queue event word.
interface ecnq_evt_if;
  logic                          valid;
  logic                          ready;
  logic [ecnq_pkg::CMD_W-1:0]    command;
  logic [ecnq_pkg::BYTES_W-1:0]  packet_bytes;
  logic [ecnq_pkg::QUANT_W-1:0]  pause_quanta;

  modport source (output valid, command, packet_bytes, pause_quanta, input ready);
  modport sink   (input valid, command, packet_bytes, pause_quanta, output ready);
endinterface

[rtl/core/ecnq_res_if.sv]
// Result channel: valid/ready handshake carrying one queue result word.
interface ecnq_res_if;
  logic                          valid;
  logic                          ready;
  logic                          dropped;
  logic                          marked_ce;
  logic [ecnq_pkg::BYTES_W-1:0]  departed_bytes;
  logic                          start_service;
  logic [ecnq_pkg::STATE_W-1:0]  send_state;
  logic [ecnq_pkg::OCC_W-1:0]    occupancy_bytes;
  logic [ecnq_pkg::DROP_W-1:0]   drop_total;
  logic                          underflow_error;

  modport source (output valid, dropped, marked_ce, departed_bytes, start_service,
                  send_state, occupancy_bytes, drop_total, underflow_error,
                  input ready);
  modport sink   (input valid, dropped, marked_ce, departed_bytes, start_service,
                  send_state, occupancy_bytes, drop_total, underflow_error,
                  output ready);
endinterface

[rtl/core/ecnq_ram.sv]
// Generic single-write, single-read RAM with registered read data.
module ecnq_ram #(
  parameter int WIDTH = 14,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // registered read port
  always_ff @(posedge clk) begin
    rdata <= mem[raddr];
  end

endmodule

[rtl/core/ecnq_ctrl.sv]
// Controller: event sequencing and result register handshake.
module ecnq_ctrl (
  input  logic                clk,
  input  logic                rst,
  input  logic                evt_valid,
  output logic                evt_ready,
  output logic                res_valid,
  input  logic                res_ready,
  output ecnq_pkg::ecnq_cmd_t cmd
);
  import ecnq_pkg::*;

  typedef enum logic [1:0] {
    ST_IDLE = 2'b01,
    ST_EXEC = 2'b10
  } state_t;

  state_t state, state_next;
  logic   can_emit;
  logic   res_valid_next;

  // result register is free when empty or being taken this cycle
  assign can_emit = !res_valid || res_ready;

  // sequence: accept, then execute once the result register is free
  always_comb begin
    state_next = state;
    evt_ready  = 1'b0;
    cmd.load   = 1'b0;
    cmd.commit = 1'b0;
    unique case (state)
      ST_IDLE: begin
        evt_ready = 1'b1;
        cmd.load  = evt_valid;
        if (evt_valid) begin
          state_next = ST_EXEC;
        end
      end
      ST_EXEC: begin
        cmd.commit = can_emit;
        if (can_emit) begin
          state_next = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  // hold the result word until the sink takes it
  always_comb begin
    if (cmd.commit) begin
      res_valid_next = 1'b1;
    end else if (res_ready) begin
      res_valid_next = 1'b0;
    end else begin
      res_valid_next = res_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      res_valid <= 1'b0;
    end else begin
      state     <= state_next;
      res_valid <= res_valid_next;
    end
  end

endmodule

[rtl/core/ecnq_dp.sv]
// Datapath: size FIFO, byte occupancy, pause state, drop count, result word.
module ecnq_dp #(
  parameter int FIFO_DEPTH = 64
) (
  input  logic                         clk,
  input  logic                         rst,
  input  ecnq_pkg::ecnq_cmd_t          cmd,
  input  logic [ecnq_pkg::CMD_W-1:0]   command,
  input  logic [ecnq_pkg::BYTES_W-1:0] packet_bytes,
  input  logic [ecnq_pkg::QUANT_W-1:0] pause_quanta,
  input  logic [ecnq_pkg::OCC_W-1:0]   max_bytes,
  input  logic [ecnq_pkg::OCC_W-1:0]   ecn_threshold,
  output ecnq_pkg::ecnq_result_t       result
);
  import ecnq_pkg::*;

  localparam int ADDR_W = (FIFO_DEPTH > 1) ? $clog2(FIFO_DEPTH) : 1;
  localparam int CNT_W  = $clog2(FIFO_DEPTH + 1);
  localparam int SUM_W  = CNT_W + 1;
  localparam logic [CNT_W-1:0]  DEPTH_CNT  = CNT_W'(FIFO_DEPTH);
  localparam logic [SUM_W-1:0]  DEPTH_SUM  = SUM_W'(FIFO_DEPTH);
  localparam logic [ADDR_W-1:0] LAST_ADDR  = ADDR_W'(FIFO_DEPTH - 1);

  // captured event word
  logic [CMD_W-1:0]   command_q;
  logic [BYTES_W-1:0] bytes_q;
  logic [QUANT_W-1:0] quanta_q;

  // queue state
  logic [CNT_W-1:0]   fifo_count, fifo_count_next;
  logic [ADDR_W-1:0]  head_pointer, head_pointer_next;
  logic [OCC_W-1:0]   queued_bytes, queued_bytes_next;
  logic [STATE_W-1:0] pause_state, pause_state_next;
  logic [DROP_W-1:0]  drop_counter, drop_counter_next;

  logic [SUM_W-1:0]   tail_sum;
  logic [ADDR_W-1:0]  tail;
  logic [OCC_W:0]     occ_sum;
  logic               drop;
  logic               push;
  logic [BYTES_W-1:0] head_bytes;
  ecnq_result_t       result_next;

  ecnq_ram #(
    .WIDTH (BYTES_W),
    .DEPTH (FIFO_DEPTH)
  ) u_size_ram (
    .clk   (clk),
    .we    (push),
    .waddr (tail),
    .wdata (bytes_q),
    .raddr (head_pointer),
    .rdata (head_bytes)
  );

  // capture the event word at accept
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      command_q <= command;
      bytes_q   <= packet_bytes;
      quanta_q  <= pause_quanta;
    end
  end

  // tail slot wraps once at most since head stays below the depth and count never exceeds it
  assign tail_sum = SUM_W'(head_pointer) + SUM_W'(fifo_count);
  always_comb begin
    if (tail_sum >= DEPTH_SUM) begin
      tail = ADDR_W'(tail_sum - DEPTH_SUM);
    end else begin
      tail = ADDR_W'(tail_sum);
    end
  end

  // admission check for arrivals
  assign occ_sum = {1'b0, queued_bytes} + {{(OCC_W + 1 - BYTES_W){1'b0}}, bytes_q};
  assign drop    = ({3'b000, bytes_q} > MAX_PACKET_BYTES) ||
                   (occ_sum > {1'b0, max_bytes}) ||
                   (fifo_count >= DEPTH_CNT);
  assign push    = cmd.commit && (command_q == CMD_DATA) && !drop;

  // event execution
  always_comb begin
    fifo_count_next   = fifo_count;
    head_pointer_next = head_pointer;
    queued_bytes_next = queued_bytes;
    pause_state_next  = pause_state;
    drop_counter_next = drop_counter;
    result_next       = '0;
    unique case (command_q)
      CMD_DATA: begin
        if (drop) begin
          result_next.dropped = 1'b1;
          drop_counter_next   = drop_counter + 1'b1;
        end else begin
          fifo_count_next   = fifo_count + 1'b1;
          queued_bytes_next = occ_sum[OCC_W-1:0];
          result_next.start_service = (fifo_count == '0) && (pause_state == SEND_READY);
        end
      end
      CMD_PAUSE: begin
        if (quanta_q != '0) begin
          pause_state_next = (queued_bytes != '0) ? SEND_PAUSE_RCVD : SEND_PAUSED;
        end else begin
          pause_state_next          = SEND_READY;
          result_next.start_service = (queued_bytes != '0);
        end
      end
      CMD_SERVICE: begin
        if (fifo_count == '0) begin
          result_next.underflow_error = 1'b1;
        end else begin
          result_next.departed_bytes = head_bytes;
          result_next.marked_ce      = (queued_bytes > ecn_threshold);
          fifo_count_next            = fifo_count - 1'b1;
          head_pointer_next = (head_pointer == LAST_ADDR) ? '0 : head_pointer + 1'b1;
          if (pause_state == SEND_PAUSE_RCVD) begin
            pause_state_next = SEND_PAUSED;
          end
          if (queued_bytes >= {{(OCC_W - BYTES_W){1'b0}}, head_bytes}) begin
            queued_bytes_next = queued_bytes - {{(OCC_W - BYTES_W){1'b0}}, head_bytes};
          end else begin
            queued_bytes_next = '0;
          end
          result_next.start_service = (fifo_count_next != '0) &&
                                      (pause_state_next == SEND_READY);
        end
      end
      default: begin
      end
    endcase
    result_next.send_state      = pause_state_next;
    result_next.occupancy_bytes = queued_bytes_next;
    result_next.drop_total      = drop_counter_next;
  end

  // commit queue state
  always_ff @(posedge clk) begin
    if (rst) begin
      fifo_count   <= '0;
      head_pointer <= '0;
      queued_bytes <= '0;
      pause_state  <= SEND_READY;
      drop_counter <= '0;
    end else if (cmd.commit) begin
      fifo_count   <= fifo_count_next;
      head_pointer <= head_pointer_next;
      queued_bytes <= queued_bytes_next;
      pause_state  <= pause_state_next;
      drop_counter <= drop_counter_next;
    end
  end

  // load the result register
  always_ff @(posedge clk) begin
    if (cmd.commit) begin
      result <= result_next;
    end
  end

endmodule

[rtl/core/ecn_marking_pausable_queue_top.sv]
// Top level of the ECN marking pausable queue: config registers and channel wiring.
//
//  channel  dir   handshake      word
//  evt      in    valid/ready    command, packet_bytes, pause_quanta
//  res      out   valid/ready    dropped .. underflow_error, one per event
//  apb      in    psel/penable   max_bytes @0x0, ecn_threshold @0x4
//
// Each event is accepted and then executed, where the size RAM's registered
// read of the head entry is consumed. An event waits in execute while the
// result register still holds an untaken word.
// Reset (rst, synchronous) clears counters, pause state and the result valid,
// and restores the config registers; the size RAM contents are not cleared.
module ecn_marking_pausable_queue_top #(
  parameter int FIFO_DEPTH = 64
) (
  input  logic                          clk,
  input  logic                          rst,
  ecnq_evt_if.sink                      evt,
  ecnq_res_if.source                    res,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [ecnq_pkg::PADDR_W-1:0]  paddr,
  input  logic [ecnq_pkg::CFG_W-1:0]    pwdata,
  output logic [ecnq_pkg::CFG_W-1:0]    prdata,
  output logic                          pready
);
  import ecnq_pkg::*;

  logic [OCC_W-1:0] max_bytes;
  logic [OCC_W-1:0] ecn_threshold;
  logic             cfg_write;
  ecnq_cmd_t        ctrl_cmd;
  ecnq_result_t     result;

  // config register file
  assign pready    = 1'b1;
  assign cfg_write = psel && penable && pwrite;

  always_ff @(posedge clk) begin
    if (rst) begin
      max_bytes     <= MAX_BYTES_RESET;
      ecn_threshold <= ECN_THRESHOLD_RESET;
    end else if (cfg_write) begin
      if (paddr[2] == REG_MAX_BYTES) begin
        max_bytes <= pwdata[OCC_W-1:0];
      end else begin
        ecn_threshold <= pwdata[OCC_W-1:0];
      end
    end
  end

  assign prdata = (paddr[2] == REG_ECN_THRESHOLD) ?
                  {{(CFG_W - OCC_W){1'b0}}, ecn_threshold} :
                  {{(CFG_W - OCC_W){1'b0}}, max_bytes};

  ecnq_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .evt_valid (evt.valid),
    .evt_ready (evt.ready),
    .res_valid (res.valid),
    .res_ready (res.ready),
    .cmd       (ctrl_cmd)
  );

  ecnq_dp #(
    .FIFO_DEPTH (FIFO_DEPTH)
  ) u_dp (
    .clk           (clk),
    .rst           (rst),
    .cmd           (ctrl_cmd),
    .command       (evt.command),
    .packet_bytes  (evt.packet_bytes),
    .pause_quanta  (evt.pause_quanta),
    .max_bytes     (max_bytes),
    .ecn_threshold (ecn_threshold),
    .result        (result)
  );

  // drive the result word
  assign res.dropped         = result.dropped;
  assign res.marked_ce       = result.marked_ce;
  assign res.departed_bytes  = result.departed_bytes;
  assign res.start_service   = result.start_service;
  assign res.send_state      = result.send_state;
  assign res.occupancy_bytes = result.occupancy_bytes;
  assign res.drop_total      = result.drop_total;
  assign res.underflow_error = result.underflow_error;

  // a committed event always shows a result word next cycle
  a_commit_shows: assert property (@(posedge clk) disable iff (rst)
    ctrl_cmd.commit |=> res.valid)
    else $error("commit did not present a result word");

  // no event is accepted while one is executing
  a_no_overlap: assert property (@(posedge clk) disable iff (rst)
    !(evt.ready && ctrl_cmd.commit))
    else $error("event accepted during execute");

  // an empty pop departs nothing
  a_underflow_clean: assert property (@(posedge clk) disable iff (rst)
    (res.valid && res.underflow_error) |-> (res.departed_bytes == '0 && !res.marked_ce))
    else $error("underflow word carries a departure");

  // a dropped arrival never starts service
  a_drop_no_start: assert property (@(posedge clk) disable iff (rst)
    (res.valid && res.dropped) |-> !res.start_service)
    else $error("dropped arrival started service");

endmodule
